// ----- rtl/core/pid_aw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the positional PID controller.
// Depends on nothing; every other file of the block but pid_aw_if imports it.
package pid_aw_pkg;

  localparam int unsigned GAIN_W         = 16;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned LIMIT_W        = 15;
  localparam int unsigned DRV_W          = LIMIT_W + 1;
  localparam int unsigned ADDR_W         = 4;
  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned GAIN_FRAC_DEF  = 8;

  localparam logic [1:0] REG_GAIN_P       = 2'd0;
  localparam logic [1:0] REG_GAIN_I       = 2'd1;
  localparam logic [1:0] REG_GAIN_D       = 2'd2;
  localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_MULP, S_MULI, S_MULD, S_SUM, S_CLAMP,
    S_DIVINIT, S_DIV, S_DIVFIX, S_DONE
  } pid_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MULP, OP_MULI, OP_MULD, OP_SUM, OP_CLAMP,
    OP_DIVINIT, OP_DIVSTEP, OP_DIVFIX, OP_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_item;
    logic backcalc;
    logic div_last;
  } dp_sts_t;

endpackage

// ----- rtl/core/pid_aw_if.sv -----
`timescale 1ns / 1ps
// Request and result channel interfaces of the PID controller.
// Valid/ready handshake; no package dependency.
interface pid_aw_req_if #(parameter int unsigned DW = 16) ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic signed [DW-1:0] target;
  logic signed [DW-1:0] measured;
  modport source (output valid, func, target, measured, input ready);
  modport sink (input valid, func, target, measured, output ready);
endinterface

interface pid_aw_rsp_if #(parameter int unsigned DW = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] drive;
  logic                 clamped;
  modport source (output valid, drive, clamped, input ready);
  modport sink (input valid, drive, clamped, output ready);
endinterface

// ----- rtl/core/positional_pid_antiwindup.sv -----
`timescale 1ns / 1ps
// Positional PID controller with back-calculation anti-windup, top level.
// Uses pid_aw_pkg, pid_aw_if, pid_aw_ctrl and pid_aw_dp.
//
// A request on req_i carries func, target and measured. A control request
// (func 0) yields one result on rsp_o with the clamped drive and a flag that
// tells whether limiting was applied; a clear request (func 1) zeroes the
// integral and the previous error and yields drive 0, clamped 0.
// Gains and the output limit are to be written over the APB port only while
// idle; the block itself does not enforce this. A clear request goes from
// S_MULP straight to S_DONE; a control request runs the multiply, sum and
// clamp states. The back-calculation then runs a restoring divider of 51
// steps, one quotient bit per cycle. One request is processed at a time, and
// the block returns to idle as the result is written, so a new request is
// accepted only after the previous result has entered the output register.
// If the receiver stalls, that result is held and a finished next result
// waits inside the block until the output register frees.
// Reset clears the state, the gains to 0 and the limit to 32767.
module positional_pid_antiwindup
  import pid_aw_pkg::*;
#(
  parameter int unsigned DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pid_aw_req_if.sink         req_i,
  pid_aw_rsp_if.source       rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0]       limit_q;
  logic                     wr_en;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;
  logic signed [DRV_W-1:0]  drive;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      limit_q  <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_GAIN_P:       gain_p_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:       gain_i_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:       gain_d_q <= pwdata[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: limit_q  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GAIN_P:       prdata = 32'(gain_p_q);
      REG_GAIN_I:       prdata = 32'(gain_i_q);
      REG_GAIN_D:       prdata = 32'(gain_d_q);
      REG_OUTPUT_LIMIT: prdata = 32'(limit_q);
      default:          prdata = '0;
    endcase
  end

  pid_aw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pid_aw_dp #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .func_i     (req_i.func),
    .target_i   (req_i.target),
    .measured_i (req_i.measured),
    .gain_p_i   (gain_p_q),
    .gain_i_i   (gain_i_q),
    .gain_d_i   (gain_d_q),
    .limit_i    (limit_q),
    .drive_o    (drive),
    .clamped_o  (rsp_o.clamped)
  );

  assign rsp_o.drive = DATA_WIDTH'(drive);

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while previous one still in progress");

  a_clamp_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.clamped |->
      (drive == DRV_W'({1'b0, limit_q})) || (drive == -DRV_W'({1'b0, limit_q})))
    else $error("clamped result not at the output limit");
`endif

endmodule

// ----- rtl/core/pid_aw_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine of the PID controller.
// Uses pid_aw_pkg; drives the datapath through dp_cmd_t.
module pid_aw_ctrl
  import pid_aw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  pid_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_MULP;
        end
      end
      S_MULP: begin
        if (sts_i.clear_item) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_MULP;
          state_d  = S_MULI;
        end
      end
      S_MULI: begin
        cmd_o.op = OP_MULI;
        state_d  = S_MULD;
      end
      S_MULD: begin
        cmd_o.op = OP_MULD;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        state_d  = sts_i.backcalc ? S_DIVINIT : S_DONE;
      end
      S_DIVINIT: begin
        cmd_o.op = OP_DIVINIT;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIVSTEP;
        if (sts_i.div_last) begin
          state_d = S_DIVFIX;
        end
      end
      S_DIVFIX: begin
        cmd_o.op = OP_DIVFIX;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_COMMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_COMMIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/pid_aw_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the PID controller: shared multiplier, sum and clamp,
// serial restoring divider for the back-calculated integral. Uses pid_aw_pkg.
module pid_aw_dp
  import pid_aw_pkg::*;
#(
  parameter int unsigned DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  output dp_sts_t                      sts_o,
  input  logic                         func_i,
  input  logic signed [DATA_WIDTH-1:0] target_i,
  input  logic signed [DATA_WIDTH-1:0] measured_i,
  input  logic signed [GAIN_W-1:0]     gain_p_i,
  input  logic signed [GAIN_W-1:0]     gain_i_i,
  input  logic signed [GAIN_W-1:0]     gain_d_i,
  input  logic [LIMIT_W-1:0]           limit_i,
  output logic signed [DRV_W-1:0]      drive_o,
  output logic                         clamped_o
);

  localparam int unsigned EW  = DATA_WIDTH + 1;
  localparam int unsigned DEW = DATA_WIDTH + 2;
  localparam int unsigned MW  = (DEW > SUM_W) ? DEW : SUM_W;
  localparam int unsigned PW  = GAIN_W + MW;
  localparam int unsigned AW  = PW + 2;
  localparam int unsigned NW  = AW + 1;
  localparam int unsigned SW  = ((EW > SUM_W) ? EW : SUM_W) + 1;
  localparam int unsigned CW  = $clog2(NW + 1);
  localparam int unsigned RW  = GAIN_W + 1;

  localparam logic signed [SW-1:0] SAT_MAX = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-32'sh7fff_ffff - 32'sd1);
  localparam logic [NW-1:0] Q_POS_MAX = {{(NW-SUM_W){1'b0}}, 32'h7fff_ffff};
  localparam logic [NW-1:0] Q_NEG_MAX = {{(NW-SUM_W){1'b0}}, 32'h8000_0000};

  logic                     func_q;
  logic signed [EW-1:0]     err_q, prev_q;
  logic signed [DEW-1:0]    diff_q;
  logic signed [SUM_W-1:0]  esum_q;
  logic signed [PW-1:0]     prod_q, p_q, i_q, d_q;
  logic signed [AW-1:0]     total_q;
  logic signed [NW-1:0]     num_q;
  logic signed [DRV_W-1:0]  drv_q, drive_q;
  logic                     clip_q, clamped_q, neg_q;
  logic [NW-1:0]            quo_q;
  logic [RW-1:0]            rem_q;
  logic [CW-1:0]            cnt_q;

  logic signed [EW-1:0]     err_c;
  logic signed [DEW-1:0]    diff_c;
  logic signed [SW-1:0]     acc_c;
  logic signed [SUM_W-1:0]  esum_sat;
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [MW-1:0]     mul_b;
  logic signed [PW-1:0]     prod_c;
  logic signed [AW-1:0]     val_c, lim_c, drv_c;
  logic                     clip_c;
  logic signed [NW-1:0]     num_c;
  logic signed [RW-1:0]     gi_ext;
  logic [RW-1:0]            dvs_c;
  logic [RW:0]              rem_sh, rem_sub;
  logic [SUM_W-1:0]         qsat_c;

  assign err_c  = EW'(target_i) - EW'(measured_i);
  assign diff_c = DEW'(err_c) - DEW'(prev_q);

  always_comb begin
    acc_c = SW'(esum_q) + SW'(err_q);
    if (acc_c > SAT_MAX) begin
      esum_sat = SAT_MAX[SUM_W-1:0];
    end else if (acc_c < SAT_MIN) begin
      esum_sat = SAT_MIN[SUM_W-1:0];
    end else begin
      esum_sat = acc_c[SUM_W-1:0];
    end
  end

  always_comb begin
    priority case (cmd_i.op)
      OP_MULI: begin
        mul_a = gain_i_i;
        mul_b = MW'(esum_q);
      end
      OP_MULD: begin
        mul_a = gain_d_i;
        mul_b = MW'(diff_q);
      end
      default: begin
        mul_a = gain_p_i;
        mul_b = MW'(err_q);
      end
    endcase
  end

  assign prod_c = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    val_c = total_q >>> GAIN_FRAC_BITS;
    lim_c = AW'({1'b0, limit_i});
    if (val_c > lim_c) begin
      drv_c = lim_c;
    end else if (val_c < -lim_c) begin
      drv_c = -lim_c;
    end else begin
      drv_c = val_c;
    end
    clip_c = (drv_c != val_c);
    num_c  = (NW'(drv_c) <<< GAIN_FRAC_BITS) - NW'(p_q) - NW'(d_q);
  end

  assign gi_ext  = RW'(gain_i_i);
  assign dvs_c   = gi_ext[RW-1] ? RW'(-gi_ext) : RW'(gi_ext);
  assign rem_sh  = {rem_q, quo_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_c};

  always_comb begin
    if (neg_q) begin
      qsat_c = (quo_q > Q_NEG_MAX) ? 32'h8000_0000 : SUM_W'(-quo_q);
    end else begin
      qsat_c = (quo_q > Q_POS_MAX) ? 32'h7fff_ffff : quo_q[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      prev_q <= '0;
    end else begin
      if (cmd_i.op == OP_MULP) begin
        esum_q <= esum_sat;
      end else if (cmd_i.op == OP_DIVFIX) begin
        esum_q <= $signed(qsat_c);
      end else if (cmd_i.op == OP_COMMIT && func_q) begin
        esum_q <= '0;
      end
      if (cmd_i.op == OP_COMMIT) begin
        prev_q <= func_q ? '0 : err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        func_q <= func_i;
        err_q  <= err_c;
        diff_q <= diff_c;
      end
      OP_MULP: prod_q <= prod_c;
      OP_MULI: begin
        p_q    <= prod_q;
        prod_q <= prod_c;
      end
      OP_MULD: begin
        i_q    <= prod_q;
        prod_q <= prod_c;
      end
      OP_SUM: begin
        d_q     <= prod_q;
        total_q <= AW'(p_q) + AW'(i_q) + AW'(prod_q);
      end
      OP_CLAMP: begin
        drv_q  <= DRV_W'(drv_c);
        clip_q <= clip_c;
        num_q  <= num_c;
      end
      OP_DIVINIT: begin
        quo_q <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
        rem_q <= '0;
        cnt_q <= CW'(NW);
        neg_q <= num_q[NW-1] ^ gain_i_i[GAIN_W-1];
      end
      OP_DIVSTEP: begin
        cnt_q <= cnt_q - CW'(1);
        if (!rem_sub[RW]) begin
          rem_q <= rem_sub[RW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[RW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
      end
      OP_COMMIT: begin
        drive_q   <= func_q ? '0 : drv_q;
        clamped_q <= func_q ? 1'b0 : clip_q;
      end
      default: ;
    endcase
  end

  assign sts_o.clear_item = func_q;
  assign sts_o.backcalc   = clip_c && (gain_i_i != '0);
  assign sts_o.div_last   = (cnt_q == CW'(1));
  assign drive_o          = drive_q;
  assign clamped_o        = clamped_q;

endmodule

// ----- sim/pid_aw_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the positional PID controller: predicts each result from the
// accepted requests and the gains and limit seen on the APB port, and compares them.
module pid_aw_checker
  import pid_aw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic        req_func,
  input  logic [15:0] req_target,
  input  logic [15:0] req_measured,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [15:0] rsp_drive,
  input  logic        rsp_clamped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] drive;
    logic        clamped;
  } pid_result_t;

  pid_result_t expected_q[$];
  longint kp, ki, kd, limit;
  longint integ, prev_err;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pid_result_t pid_step(logic func, logic [15:0] tgt, logic [15:0] meas);
    pid_result_t r;
    longint err, p, d, total, val, drv, num;
    if (func) begin
      integ = 0;
      prev_err = 0;
      r.drive = '0;
      r.clamped = 1'b0;
      return r;
    end
    err = longint'($signed(tgt)) - longint'($signed(meas));
    integ = clip32(integ + err);
    p = kp * err;
    d = kd * (err - prev_err);
    total = p + ki * integ + d;
    val = total >>> 8;
    drv = val;
    if (drv > limit) drv = limit;
    if (drv < -limit) drv = -limit;
    if (drv != val && ki != 0) begin
      num = drv * 256 - p - d;
      integ = clip32(num / ki);
    end
    prev_err = err;
    r.drive = drv[15:0];
    r.clamped = (drv != val);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pid_result_t got, exp_r;
    if (!rst_ni) begin
      kp = 0; ki = 0; kd = 0; limit = 32767;
      integ = 0; prev_err = 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_GAIN_P: kp = longint'($signed(pwdata[15:0]));
          REG_GAIN_I: ki = longint'($signed(pwdata[15:0]));
          REG_GAIN_D: kd = longint'($signed(pwdata[15:0]));
          REG_OUTPUT_LIMIT: limit = longint'(pwdata[14:0]);
          default: ;
        endcase
      end
      if (req_valid && req_ready)
        expected_q.push_back(pid_step(req_func, req_target, req_measured));
      if (rsp_valid && rsp_ready) begin
        got.drive = rsp_drive;
        got.clamped = rsp_clamped;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result drive=%0d", $signed(rsp_drive));
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) begin
            if (fail_count < 10)
              $display("Mismatch: expected drive=%0d clamped=%0b, got drive=%0d clamped=%0b",
                       $signed(exp_r.drive), exp_r.clamped, $signed(got.drive), got.clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/positional_pid_antiwindup_test.sv -----
`timescale 1ns / 1ps
// Testbench top of the positional PID controller: drives requests, register
// writes and result stalls; uses pid_aw_pkg, pid_aw_if and pid_aw_checker.
module positional_pid_antiwindup_test;
  import pid_aw_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int send_idle, recv_stall;

  pid_aw_req_if #(16) req ();
  pid_aw_rsp_if #(16) rsp ();

  always #2 clk_i = ~clk_i;

  positional_pid_antiwindup dut (
    .clk_i, .rst_ni, .req_i(req.sink), .rsp_o(rsp.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pid_aw_checker checker_i (
    .clk_i, .rst_ni,
    .req_valid(req.valid), .req_ready(req.ready), .req_func(req.func),
    .req_target(req.target), .req_measured(req.measured),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_drive(rsp.drive),
    .rsp_clamped(rsp.clamped),
    .psel, .penable, .pwrite, .paddr, .pwdata, .fail_count, .pending
  );

  initial begin
    req.valid = 1'b0;
    req.func = 1'b0;
    req.target = '0;
    req.measured = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_request(logic func, logic [15:0] tgt, logic [15:0] meas);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    req.valid <= 1'b1;
    req.func <= func;
    req.target <= tgt;
    req.measured <= meas;
    do @(posedge clk_i); while (!req.ready);
    req.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_value(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(400)) - 200);
      default: return 16'($urandom_range(1) ? 16'h7fff : 16'h8000);
    endcase
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    int mode;
    logic [15:0] sp;
    send_idle = idle;
    recv_stall = stall;
    write_reg(REG_GAIN_P, 32'($urandom_range(1) ? $urandom : $urandom_range(1024)));
    write_reg(REG_GAIN_I, 32'($urandom_range(3) == 0 ? 0 : $urandom_range(512)));
    write_reg(REG_GAIN_D, 32'($urandom));
    write_reg(REG_OUTPUT_LIMIT, 32'($urandom_range(3) == 0 ? $urandom : $urandom_range(3000)));
    sp = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(9);
      if (mode == 0) send_request(1'b1, 16'($urandom), 16'($urandom));
      else if (mode < 6) send_request(1'b0, sp, sp + rand_value(1));
      else send_request(1'b0, rand_value(mode % 3), rand_value(mode % 2));
    end
    wait_idle();
  endtask

  initial begin
    send_idle = 0;
    recv_stall = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    send_request(1'b0, 16'h7fff, 16'h8000);
    send_request(1'b0, 16'h8000, 16'h7fff);
    wait_idle();
    write_reg(REG_GAIN_P, 32'h7fff);
    write_reg(REG_GAIN_I, 32'h8000);
    write_reg(REG_GAIN_D, 32'h8000);
    write_reg(REG_OUTPUT_LIMIT, 32'h7fff);
    for (int k = 0; k < 5; k++) send_request(1'b0, 16'h7fff, 16'h8000);
    send_request(1'b0, 16'h8000, 16'h7fff);
    send_request(1'b1, 16'hffff, 16'hffff);
    wait_idle();
    write_reg(REG_GAIN_I, 32'h7fff);
    write_reg(REG_OUTPUT_LIMIT, 32'h0);
    send_request(1'b0, 16'h0010, 16'h0000);
    send_request(1'b0, 16'h0000, 16'h0000);
    send_request(1'b0, 16'h8000, 16'h7fff);
    wait_idle();
    write_reg(REG_GAIN_I, 32'h0);
    write_reg(REG_OUTPUT_LIMIT, 32'h0064);
    for (int k = 0; k < 4; k++) send_request(1'b0, 16'h7fff, 16'h8000);
    send_request(1'b0, 16'h0000, 16'h0000);
    send_request(1'b1, 16'h0000, 16'h0000);
    wait_idle();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: run_phase(105, 0, 0);
        1: run_phase(105, 57, 0);
        2: run_phase(105, 0, 57);
        default: run_phase(105, 37, 37);
      endcase
    end
    write_reg(REG_OUTPUT_LIMIT, 32'h7fff);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
